/* rtl/bhr_pkg.sv */
package bhr_pkg;

	localparam int unsigned VOLT_W   = 16;
	localparam int unsigned HEAD_W   = 17;
	localparam int unsigned MIN_W    = 18;
	localparam int unsigned FILT_W   = 26;
	localparam int unsigned FRAC_W   = 8;
	localparam int unsigned DIFF_W   = 27;
	localparam int unsigned PROD_W   = 39;
	localparam int unsigned GAIN_SH  = 14;
	localparam int unsigned STEP_W   = 10;
	localparam int unsigned CMD_W    = 16;
	localparam int unsigned SUM_W    = 18;
	localparam int unsigned IDX_W    = 3;

	localparam logic signed [MIN_W-1:0]  MIN_CEILING  = 18'sd100000;
	localparam logic signed [FILT_W-1:0] FILTER_START = 26'sd512000;
	localparam logic signed [PROD_W-1:0] FILTER_GAIN  = 39'sd1638;

	localparam logic [IDX_W-1:0] REG_MARGIN_LO       = 3'd0;
	localparam logic [IDX_W-1:0] REG_MARGIN_HI       = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEP_UP         = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP_DOWN       = 3'd3;
	localparam logic [IDX_W-1:0] REG_COMMAND_FLOOR   = 3'd4;
	localparam logic [IDX_W-1:0] REG_COMMAND_CEILING = 3'd5;
	localparam logic [IDX_W-1:0] REG_COMMAND_START   = 3'd6;

	localparam logic [VOLT_W-1:0] RST_MARGIN_LO       = 16'd2250;
	localparam logic [VOLT_W-1:0] RST_MARGIN_HI       = 16'd2750;
	localparam logic [STEP_W-1:0] RST_STEP_UP         = 10'd1;
	localparam logic [STEP_W-1:0] RST_STEP_DOWN       = 10'd1;
	localparam logic [CMD_W-1:0]  RST_COMMAND_FLOOR   = 16'd0;
	localparam logic [CMD_W-1:0]  RST_COMMAND_CEILING = 16'd60000;
	localparam logic [CMD_W-1:0]  RST_COMMAND_START   = 16'd45000;

	typedef struct packed {
		logic [VOLT_W-1:0] margin_lo;
		logic [VOLT_W-1:0] margin_hi;
		logic [STEP_W-1:0] step_up;
		logic [STEP_W-1:0] step_down;
		logic [CMD_W-1:0]  command_floor;
		logic [CMD_W-1:0]  command_ceiling;
		logic [CMD_W-1:0]  command_start;
	} cfg_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic pop;
		logic s1_valid;
	} back_stat_t;

endpackage

/* rtl/bhr_front.sv */
module bhr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [15:0]               chan_mv,
	input  logic [15:0]               channel_current,
	input  logic                      last_channel,
	input  bhr_pkg::q_stat_t          q_stat,
	output logic                      push,
	output logic signed [16:0]        push_min
);
	import bhr_pkg::*;

	logic                     acc;
	logic signed [HEAD_W-1:0] head;
	logic signed [MIN_W-1:0]  head_ext;
	logic signed [MIN_W-1:0]  next_min;
	logic signed [MIN_W-1:0]  run_min_q;

	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;
	assign head     = $signed({1'b0, chan_mv}) - $signed({1'b0, channel_current});
	assign head_ext = MIN_W'(head);
	assign next_min = (head_ext < run_min_q) ? head_ext : run_min_q;

	// a closed frame minimum never exceeds one channel headroom
	assign push     = acc && last_channel;
	assign push_min = next_min[HEAD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= MIN_CEILING;
		end else if (acc) begin
			run_min_q <= last_channel ? MIN_CEILING : next_min;
		end
	end

endmodule

/* rtl/bhr_queue.sv */
module bhr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic signed [16:0] push_min,
	input  logic               pop,
	output logic signed [16:0] head_min,
	output bhr_pkg::q_stat_t   q_stat
);
	import bhr_pkg::*;

	logic signed [HEAD_W-1:0] slot_q [2];
	logic                     wr_ptr_q;
	logic                     rd_ptr_q;
	logic [1:0]               count_q;

	assign head_min         = slot_q[rd_ptr_q];
	assign q_stat.not_empty = (count_q != 2'd0);
	assign q_stat.full      = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_min;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/bhr_back.sv */
module bhr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bhr_pkg::cfg_t       cfg,
	input  logic                start_load,
	input  logic [15:0]         start_value,
	input  logic                q_not_empty,
	input  logic signed [16:0]  head_min,
	output bhr_pkg::back_stat_t stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         boost_command,
	output logic signed [16:0]  filtered_headroom,
	output logic signed [16:0]  frame_minimum
);
	import bhr_pkg::*;

	logic                      s1_valid_q;
	logic signed [HEAD_W-1:0]  fmin_s1;
	logic signed [FILT_W-1:0]  filter_q;
	logic [CMD_W-1:0]          command_q;
	logic                      out_valid_q;

	logic                      adv2;
	logic                      pop;
	logic signed [DIFF_W-1:0]  diff;
	logic signed [PROD_W-1:0]  prod;
	logic signed [FILT_W-1:0]  filter_next;
	logic signed [FILT_W-1:0]  low_fx;
	logic signed [FILT_W-1:0]  high_fx;
	logic signed [SUM_W-1:0]   cmd_sum;
	logic signed [SUM_W-1:0]   cmd_ceil;
	logic [CMD_W-1:0]          cmd_new;

	assign adv2 = s1_valid_q && (!out_valid_q || out_ready);
	assign pop  = q_not_empty && (!s1_valid_q || adv2);

	assign stat.pop      = pop;
	assign stat.s1_valid = s1_valid_q;

	// first-order filter, increment rounded toward minus infinity
	assign diff        = DIFF_W'($signed({head_min, {FRAC_W{1'b0}}})) - DIFF_W'(filter_q);
	assign prod        = PROD_W'(diff) * FILTER_GAIN;
	assign filter_next = filter_q + FILT_W'(prod >>> GAIN_SH);

	assign low_fx  = $signed({2'b00, cfg.margin_lo, {FRAC_W{1'b0}}});
	assign high_fx = $signed({2'b00, cfg.margin_hi, {FRAC_W{1'b0}}});

	always_comb begin
		if (filter_q < low_fx) begin
			cmd_sum = $signed({2'b00, command_q}) + $signed({8'b0, cfg.step_up});
		end else if (filter_q > high_fx) begin
			cmd_sum = $signed({2'b00, command_q}) - $signed({8'b0, cfg.step_down});
		end else begin
			cmd_sum = $signed({2'b00, command_q});
		end
		if (cmd_sum > $signed({2'b00, cfg.command_ceiling})) begin
			cmd_ceil = $signed({2'b00, cfg.command_ceiling});
		end else begin
			cmd_ceil = cmd_sum;
		end
		// floor last, so it wins over the ceiling
		if (cmd_ceil < $signed({2'b00, cfg.command_floor})) begin
			cmd_new = cfg.command_floor;
		end else begin
			cmd_new = cmd_ceil[CMD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			filter_q    <= FILTER_START;
			command_q   <= RST_COMMAND_START;
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
				filter_q   <= filter_next;
			end else if (adv2) begin
				s1_valid_q <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (start_load) begin
				command_q <= start_value;
			end else if (adv2) begin
				command_q <= cmd_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fmin_s1 <= head_min;
		end
		if (adv2) begin
			boost_command     <= cmd_new;
			filtered_headroom <= filter_q[FILT_W-2:FRAC_W];
			frame_minimum     <= fmin_s1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/boost_headroom_regulator_unit.sv */
// boost headroom regulator
// input channel: one word per channel sample (voltage, current, last_channel
// mark) on in_valid/in_ready. headroom is voltage minus current; a running
// minimum is kept until the word marked last_channel closes the frame.
// output channel: one word per frame on out_valid/out_ready carrying the
// new clamped boost command, the filtered headroom and the frame minimum.
// throughput: one sample word per cycle while the frame queue is not full,
// and frames may be one word long. a closing word passes the frame queue,
// the filter stage and the output register before out_valid rises.
// the filter multiply sits in its own stage, the command step and clamp in
// the output stage; a two-word frame queue splits input and output sides.
// receiver stall: the output word holds, the filter stage and the queue
// fill, then in_ready drops once the queue is full.
// reset: config registers return to their defaults, the filter to 2000 mV,
// the command to 45000 mV and the running minimum to 100000 mV.
// writing command_start also loads the command at once.
module boost_headroom_regulator_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        chan_mv,
	input  logic [15:0]        channel_current,
	input  logic               last_channel,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        boost_command,
	output logic signed [16:0] filtered_headroom,
	output logic signed [16:0] frame_minimum,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import bhr_pkg::*;

	cfg_t                     cfg_q;
	q_stat_t                  q_stat;
	back_stat_t               back_stat;
	logic                     push;
	logic signed [HEAD_W-1:0] push_min;
	logic signed [HEAD_W-1:0] head_min;
	logic                     start_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.margin_lo       <= RST_MARGIN_LO;
			cfg_q.margin_hi       <= RST_MARGIN_HI;
			cfg_q.step_up         <= RST_STEP_UP;
			cfg_q.step_down       <= RST_STEP_DOWN;
			cfg_q.command_floor   <= RST_COMMAND_FLOOR;
			cfg_q.command_ceiling <= RST_COMMAND_CEILING;
			cfg_q.command_start   <= RST_COMMAND_START;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MARGIN_LO:       cfg_q.margin_lo       <= cfg_data;
				REG_MARGIN_HI:       cfg_q.margin_hi       <= cfg_data;
				REG_STEP_UP:         cfg_q.step_up         <= cfg_data[STEP_W-1:0];
				REG_STEP_DOWN:       cfg_q.step_down       <= cfg_data[STEP_W-1:0];
				REG_COMMAND_FLOOR:   cfg_q.command_floor   <= cfg_data;
				REG_COMMAND_CEILING: cfg_q.command_ceiling <= cfg_data;
				REG_COMMAND_START:   cfg_q.command_start   <= cfg_data;
				default:             cfg_q <= cfg_q;
			endcase
		end
	end

	assign start_load = cfg_we && (cfg_index == REG_COMMAND_START);

	bhr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.chan_mv         (chan_mv),
		.channel_current (channel_current),
		.last_channel    (last_channel),
		.q_stat          (q_stat),
		.push            (push),
		.push_min        (push_min)
	);

	bhr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_min (push_min),
		.pop      (back_stat.pop),
		.head_min (head_min),
		.q_stat   (q_stat)
	);

	bhr_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.start_load        (start_load),
		.start_value       (cfg_data),
		.q_not_empty       (q_stat.not_empty),
		.head_min          (head_min),
		.stat              (back_stat),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.boost_command     (boost_command),
		.filtered_headroom (filtered_headroom),
		.frame_minimum     (frame_minimum)
	);

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> q_stat.not_empty)
		else $error("frame queue popped while empty");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> q_stat.not_empty)
		else $error("closed frame word lost in queue");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(back_stat.s1_valid))
		else $error("output word without filter stage word");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !in_ready)
		else $error("input taken while frame queue full");

endmodule
